// File: hw/rtl/smsd_pkg.sv
package smsd_pkg;

	localparam int MAX_SAMPLES = 1024;

	localparam int SMP_W   = 24;
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int LOG_MAX = $clog2(MAX_SAMPLES);
	localparam int SUM_W   = SMP_W + LOG_MAX;
	localparam int SQ_W    = 2 * SMP_W + LOG_MAX;
	localparam int DIFF_W  = CNT_W + SQ_W;
	localparam int DVS_W   = 2 * CNT_W;
	localparam int REM_W   = DVS_W + 1;
	localparam int Q_W     = 48;
	localparam int AW      = DIFF_W + 1;
	localparam int STEP_W  = $clog2(Q_W);

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_SINGLE   = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	typedef struct packed {
		logic signed [23:0] sample;
		logic               last_sample;
	} in_t;

	typedef struct packed {
		logic signed [23:0] mean;
		logic [23:0]        std_deviation;
		logic [10:0]        accepted_count;
		logic [1:0]         status;
	} out_t;

endpackage

// File: hw/rtl/sample_mean_and_std_deviation.sv
// Mean and sample standard deviation of a run of signed Q12.12 samples.
// A sample is taken at a clock edge with start high and busy low. Samples
// below 1.0 in magnitude are dropped; past MAX_SAMPLES accepted samples the
// rest are dropped and the status reports overflow. A sample that is not
// marked last leaves busy low, so one beat per cycle while busy is low.
// The last beat starts a sequencer that drives one shared adder/subtractor
// one bit per cycle (restoring divides of 48 quotient bits, shift-add
// multiplies, a 24-step square root); it stops after its first step with no
// samples and after the mean divide with one sample. The
// result is on result for exactly one cycle with done high and cannot be
// held off; busy falls in that same cycle and the accumulators start over.
module sample_mean_and_std_deviation (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  smsd_pkg::in_t item,
	output logic          done,
	output smsd_pkg::out_t result
);
	import smsd_pkg::*;

	localparam logic [2:0] SM_IDLE = 3'd0;
	localparam logic [2:0] SM_ABS  = 3'd1;
	localparam logic [2:0] SM_MEAN = 3'd2;
	localparam logic [2:0] SM_DVS  = 3'd3;
	localparam logic [2:0] SM_SQ   = 3'd4;
	localparam logic [2:0] SM_SS   = 3'd5;
	localparam logic [2:0] SM_DIV  = 3'd6;
	localparam logic [2:0] SM_SQRT = 3'd7;

	logic [2:0]              state_q;
	logic                    done_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    ovf_q;

	logic [STEP_W-1:0]       step_q;
	logic [SUM_W-1:0]        mag_q;
	logic                    neg_q;
	logic [DIFF_W-1:0]       acc_q;
	logic [DIFF_W-1:0]       md_q;
	logic [SUM_W-1:0]        mq_q;
	logic [REM_W-1:0]        rem_q;
	logic [DVS_W-1:0]        dvs_q;
	logic [Q_W-1:0]          num_q;
	logic [Q_W-1:0]          root_q;
	logic [Q_W-1:0]          bit_q;
	logic signed [23:0]      mean_q;
	out_t                    result_q;

	logic                    accept;
	logic                    missing;
	logic                    full;
	logic signed [47:0]      sq_full;

	logic [AW-1:0]           alu_a;
	logic [AW-1:0]           alu_b;
	logic                    alu_sub;
	logic [AW-1:0]           alu_y;
	logic                    take;

	logic [SUM_W-1:0]        abs_val;
	logic [DIFF_W-1:0]       acc_next;
	logic [REM_W-1:0]        rem_shift;
	logic [REM_W-1:0]        rem_next;
	logic [Q_W-1:0]          num_next;
	logic [Q_W-1:0]          root_next;
	logic                    last_step;
	logic                    emit;

	assign busy   = (state_q != SM_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign missing = (item.sample[23:12] == '0) ||
		((item.sample[23:12] == '1) && (item.sample[11:0] != '0));
	assign full    = (cnt_q >= CNT_W'(MAX_SAMPLES));
	assign sq_full = item.sample * item.sample;

	assign rem_shift = {rem_q[REM_W-2:0], num_q[Q_W-1]};

	// shared adder/subtractor
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			SM_ABS: begin
				alu_b   = AW'(sum_q);
				alu_sub = 1'b1;
			end
			SM_MEAN, SM_DIV: begin
				alu_a   = AW'(rem_shift);
				alu_b   = AW'(dvs_q);
				alu_sub = 1'b1;
			end
			SM_DVS, SM_SQ: begin
				alu_a = AW'(acc_q);
				alu_b = AW'(md_q);
			end
			SM_SS: begin
				alu_a   = AW'(acc_q);
				alu_b   = AW'(md_q);
				alu_sub = 1'b1;
			end
			SM_SQRT: begin
				alu_a   = AW'(num_q);
				alu_b   = AW'(root_q | bit_q);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
		alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
	end

	assign take      = !alu_y[AW-1];
	assign abs_val   = sum_q[SUM_W-1] ? alu_y[SUM_W-1:0] : SUM_W'($unsigned(sum_q));
	assign acc_next  = mq_q[0] ? alu_y[DIFF_W-1:0] : acc_q;
	assign rem_next  = take ? alu_y[REM_W-1:0] : rem_shift;
	assign num_next  = {num_q[Q_W-2:0], take};
	assign root_next = take ? ((root_q >> 1) | bit_q) : (root_q >> 1);
	assign last_step = (step_q == '0);

	// result is formed this cycle
	always_comb begin
		unique case (state_q)
			SM_ABS:  emit = (cnt_q == '0);
			SM_MEAN: emit = last_step && (cnt_q == CNT_W'(1));
			SM_SQRT: emit = last_step;
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SM_IDLE;
			done_q  <= 1'b0;
			sum_q   <= '0;
			sumsq_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= emit;
			if (emit) begin
				sum_q   <= '0;
				sumsq_q <= '0;
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (accept && !missing) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					sum_q   <= sum_q + SUM_W'(item.sample);
					sumsq_q <= sumsq_q + SQ_W'($unsigned(sq_full));
					cnt_q   <= cnt_q + CNT_W'(1);
				end
			end
			unique case (state_q)
				SM_IDLE: begin
					if (accept && item.last_sample) begin
						state_q <= SM_ABS;
					end
				end
				SM_ABS: begin
					state_q <= emit ? SM_IDLE : SM_MEAN;
				end
				SM_MEAN: begin
					if (last_step) begin
						state_q <= emit ? SM_IDLE : SM_DVS;
					end
				end
				SM_DVS: begin
					if (last_step) begin
						state_q <= SM_SQ;
					end
				end
				SM_SQ: begin
					if (last_step) begin
						state_q <= SM_SS;
					end
				end
				SM_SS: begin
					if (last_step) begin
						state_q <= SM_DIV;
					end
				end
				SM_DIV: begin
					if (last_step) begin
						state_q <= SM_SQRT;
					end
				end
				SM_SQRT: begin
					if (last_step) begin
						state_q <= SM_IDLE;
					end
				end
				default: state_q <= SM_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		step_q <= step_q - STEP_W'(1);
		unique case (state_q)
			SM_ABS: begin
				mag_q  <= abs_val;
				neg_q  <= sum_q[SUM_W-1];
				rem_q  <= '0;
				num_q  <= Q_W'(abs_val);
				dvs_q  <= DVS_W'(cnt_q);
				step_q <= STEP_W'(Q_W - 1);
			end
			SM_MEAN: begin
				rem_q <= rem_next;
				num_q <= num_next;
				if (last_step) begin
					mean_q <= neg_q ? -$signed(num_next[23:0]) : $signed(num_next[23:0]);
					acc_q  <= '0;
					md_q   <= DIFF_W'(cnt_q - CNT_W'(1));
					mq_q   <= SUM_W'(cnt_q);
					step_q <= STEP_W'(CNT_W - 1);
				end
			end
			SM_DVS: begin
				acc_q <= acc_next;
				md_q  <= md_q << 1;
				mq_q  <= mq_q >> 1;
				if (last_step) begin
					dvs_q  <= DVS_W'(acc_next);
					acc_q  <= '0;
					md_q   <= DIFF_W'(sumsq_q);
					mq_q   <= SUM_W'(cnt_q);
					step_q <= STEP_W'(CNT_W - 1);
				end
			end
			SM_SQ: begin
				acc_q <= acc_next;
				md_q  <= md_q << 1;
				mq_q  <= mq_q >> 1;
				if (last_step) begin
					md_q   <= DIFF_W'(mag_q);
					mq_q   <= mag_q;
					step_q <= STEP_W'(SUM_W - 1);
				end
			end
			SM_SS: begin
				acc_q <= acc_next;
				md_q  <= md_q << 1;
				mq_q  <= mq_q >> 1;
				if (last_step) begin
					rem_q  <= REM_W'(acc_next >> Q_W);
					num_q  <= acc_next[Q_W-1:0];
					step_q <= STEP_W'(Q_W - 1);
				end
			end
			SM_DIV: begin
				rem_q <= rem_next;
				num_q <= num_next;
				if (last_step) begin
					root_q <= '0;
					bit_q  <= Q_W'(1) << (Q_W - 2);
					step_q <= STEP_W'(Q_W / 2 - 1);
				end
			end
			SM_SQRT: begin
				if (take) begin
					num_q <= alu_y[Q_W-1:0];
				end
				root_q <= root_next;
				bit_q  <= bit_q >> 2;
			end
			default: begin
			end
		endcase

		if (emit) begin
			result_q.accepted_count <= 11'(cnt_q);
			unique case (state_q)
				SM_ABS: begin
					result_q.mean          <= '0;
					result_q.std_deviation <= '0;
					result_q.status        <= STAT_EMPTY;
				end
				SM_MEAN: begin
					result_q.mean          <= neg_q ? -$signed(num_next[23:0])
						: $signed(num_next[23:0]);
					result_q.std_deviation <= '0;
					result_q.status        <= STAT_SINGLE;
				end
				default: begin
					result_q.mean          <= mean_q;
					result_q.std_deviation <= (|root_next[Q_W-1:24]) ? '1 : root_next[23:0];
					result_q.status        <= ovf_q ? STAT_OVERFLOW : STAT_OK;
				end
			endcase
		end
	end

endmodule

// File: sim/smsd_stats_monitor.sv
`timescale 1ns / 100ps

module smsd_stats_monitor
	import smsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  in_t  item,
	input  logic done,
	input  out_t result,
	output int   miscompares,
	output int   stats_outstanding
);

	logic signed [SUM_W-1:0] sum_acc;
	logic [SQ_W-1:0]         sq_acc;
	logic [CNT_W-1:0]        n_acc;
	bit                      over_acc;
	out_t                    awaited_stats[$];

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = '0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// floor(sqrt((N*sumsq - sum^2) / (N*(N-1)))), saturated to 24 bits
	function automatic logic [23:0] spread_of(logic signed [SUM_W-1:0] s,
			logic [SQ_W-1:0] q, logic [CNT_W-1:0] n);
		logic [SUM_W-1:0] mag;
		logic [127:0]     lhs;
		logic [127:0]     rhs;
		logic [127:0]     quot;
		logic [63:0]      r;
		mag = (s < 0) ? -s : s;
		lhs = 128'(n) * 128'(q);
		rhs = 128'(mag) * 128'(mag);
		if (lhs < rhs)
			return '0;
		quot = (lhs - rhs) / (128'(n) * (128'(n) - 128'd1));
		r = root_floor(quot[63:0]);
		return (r > 64'hFF_FFFF) ? 24'hFF_FFFF : r[23:0];
	endfunction

	always @(posedge clk) begin
		out_t want;
		int   v;
		if (!arst_n) begin
			sum_acc = '0;
			sq_acc = '0;
			n_acc = '0;
			over_acc = 1'b0;
			miscompares = 0;
			awaited_stats.delete();
		end else begin
			if (done) begin
				if (awaited_stats.size() == 0) begin
					miscompares++;
					if (miscompares <= 10)
						$display("%0t: result with none pending: mean %0d sd %0d n %0d st %0d",
							$realtime, result.mean, result.std_deviation,
							result.accepted_count, result.status);
				end else begin
					want = awaited_stats.pop_front();
					if (result.mean !== want.mean
							|| result.std_deviation !== want.std_deviation
							|| result.accepted_count !== want.accepted_count
							|| result.status !== want.status) begin
						miscompares++;
						if (miscompares <= 10)
							$display({"%0t: mismatch: exp mean %0d sd %0d n %0d st %0d,",
								" got mean %0d sd %0d n %0d st %0d"}, $realtime,
								want.mean, want.std_deviation, want.accepted_count,
								want.status, result.mean, result.std_deviation,
								result.accepted_count, result.status);
					end
				end
			end
			if (start && !busy) begin
				v = int'($signed(item.sample));
				if (v >= 4096 || v <= -4096) begin
					if (n_acc < MAX_SAMPLES) begin
						sum_acc = sum_acc + v;
						sq_acc = sq_acc + SQ_W'(longint'(v) * longint'(v));
						n_acc = n_acc + 1'b1;
					end else begin
						over_acc = 1'b1;
					end
				end
				if (item.last_sample) begin
					want = '0;
					want.accepted_count = n_acc;
					if (n_acc == 0) begin
						want.status = STAT_EMPTY;
					end else begin
						want.mean = 24'(longint'(sum_acc) / longint'(n_acc));
						if (n_acc == 1) begin
							want.status = STAT_SINGLE;
						end else begin
							want.std_deviation = spread_of(sum_acc, sq_acc, n_acc);
							want.status = over_acc ? STAT_OVERFLOW : STAT_OK;
						end
					end
					awaited_stats.push_back(want);
					sum_acc = '0;
					sq_acc = '0;
					n_acc = '0;
					over_acc = 1'b0;
				end
			end
		end
		stats_outstanding = awaited_stats.size();
	end

endmodule

// File: sim/sample_mean_and_std_deviation_test.sv
`timescale 1ns / 100ps

module sample_mean_and_std_deviation_test;
	import smsd_pkg::*;

	localparam int CYCLE_LIMIT = 600_000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	in_t  item;
	out_t result;

	int miscompares;
	int stats_outstanding;
	int cycle_count;
	int burst_left;
	bit steady;
	int runs_sent;
	int beats_random;

	sample_mean_and_std_deviation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	smsd_stats_monitor monitor (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.item              (item),
		.done              (done),
		.result            (result),
		.miscompares       (miscompares),
		.stats_outstanding (stats_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("sample_mean_and_std_deviation_test: FAIL");
		$finish;
	end

	task automatic hold_off(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// pause the sender until every pending result is out
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (stats_outstanding != 0)
			@(negedge clk);
	endtask

	// one beat; called and returns at a falling edge
	task automatic push_sample(input logic signed [23:0] s, input bit fin);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady && $urandom_range(0, 3) != 0)
				hold_off($urandom_range(1, 8));
		end
		burst_left--;
		start <= 1'b1;
		item <= '{sample: s, last_sample: fin};
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (fin)
			runs_sent++;
	endtask

	function automatic logic signed [23:0] pick_sample();
		int k;
		case ($urandom_range(0, 9))
			0: begin
				k = $urandom_range(0, 8190);
				return 24'(k - 4095);
			end
			1: begin
				case ($urandom_range(0, 5))
					0: return 24'sd4095;
					1: return -24'sd4095;
					2: return 24'sd4096;
					3: return -24'sd4096;
					4: return 24'h7F_FFFF;
					default: return 24'h80_0000;
				endcase
			end
			2: begin
				k = $urandom_range(4096, 65535);
				return $urandom_range(0, 1) ? 24'(k) : 24'(-k);
			end
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		int len;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		burst_left = 0;
		steady = 1'b0;
		runs_sent = 0;
		beats_random = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty runs
		push_sample(24'sd0, 1'b1);
		push_sample(24'sd4095, 1'b1);
		// single sample, after a missing one
		push_sample(-24'sd4095, 1'b0);
		push_sample(24'sd4096, 1'b1);
		push_sample(24'h80_0000, 1'b1);
		// extremes
		push_sample(24'h7F_FFFF, 1'b0);
		push_sample(24'h80_0000, 1'b1);
		push_sample(24'h7F_FFFF, 1'b0);
		push_sample(24'h7F_FFFF, 1'b1);
		// negative mean truncates toward zero
		push_sample(-24'sd4096, 1'b0);
		push_sample(-24'sd8193, 1'b0);
		push_sample(24'sd12, 1'b0);
		push_sample(-24'sd4096, 1'b1);
		// last beat itself missing
		push_sample(24'sd4096, 1'b0);
		push_sample(-24'sd4096, 1'b0);
		push_sample(-24'sd4096, 1'b0);
		push_sample(24'sd0, 1'b1);
		push_sample(24'sd123456, 1'b0);
		push_sample(-24'sd987654, 1'b1);
		drain();

		// count reaches full at widest spread, then further samples are dropped
		steady = 1'b1;
		len = MAX_SAMPLES + 2;
		for (int i = 0; i < len; i++)
			push_sample((i % 2 == 0) ? 24'h7F_FFFF : 24'h80_0000, i == len - 1);
		steady = 1'b0;
		drain();

		runs_sent = 0;
		while (beats_random < 450 || runs_sent < 40) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
				: $urandom_range(1, 12);
			steady = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++)
				push_sample(pick_sample(), i == len - 1);
			beats_random += len;
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		drain();
		repeat (200) @(negedge clk);
		if (miscompares == 0 && stats_outstanding == 0)
			$display("sample_mean_and_std_deviation_test: PASS");
		else
			$display("sample_mean_and_std_deviation_test: FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/smsd_pkg.sv
hw/rtl/sample_mean_and_std_deviation.sv
sim/smsd_stats_monitor.sv
sim/sample_mean_and_std_deviation_test.sv
